FILE: rtl/iat_pkg.sv
// Shared types and constants for the indexed array table.
// Holds command and status codes, item field widths and the cell control and status types.
// No dependencies.
package iat_pkg;

    // Item field widths
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 32;
    localparam int FOUND_W  = 5;
    localparam int COUNT_W  = 5;

    // Packed item widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_SEARCH = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // What a cell loads at the next edge
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_PREV = 2'd1,
        SEL_NEXT = 2'd2,
        SEL_LOAD = 2'd3
    } t_cell_sel;

    // Per-cell control from the top level
    typedef struct packed {
        t_cell_sel sel;
        logic      live;
    } t_cell_ctl;

    // Per-cell search status back to the top level
    typedef struct packed {
        logic hit;
        logic first;
    } t_cell_sts;

endpackage

FILE: rtl/indexed_array_table_unit.sv
// Indexed array table: bounded ordered array held in a chain of word cells.
// Each accepted item's result is loaded into the output register in the cycle after acceptance.
// Throughput: one item per cycle; every cell shifts or compares in parallel, and
// the output register lets a new item in whenever the pending result is taken.
// Reset: synchronous active-low reset clears the fill count and output valid;
// cell contents are left undefined until written.
module indexed_array_table_unit #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // kind [2:0], position [7:3], value [39:8]
    input  logic [iat_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status [1:0], read_data [33:2], found_index [38:34], count [43:39], zero pad
    output logic [iat_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > iat_pkg::POS_W) ? CW : iat_pkg::POS_W;
    localparam int KW = (WIDTH > iat_pkg::VALUE_W) ? WIDTH : iat_pkg::VALUE_W;
    localparam int OUT_USED = iat_pkg::STATUS_W + iat_pkg::RDATA_W
                            + iat_pkg::FOUND_W + iat_pkg::COUNT_W;

    // Input field unpacking
    iat_pkg::t_kind                 kind;
    logic [iat_pkg::POS_W-1:0]      position;
    logic [iat_pkg::VALUE_W-1:0]    value;
    logic [KW-1:0]                  value_ext;
    logic [WIDTH-1:0]               key;

    // Control and state
    logic                           r_m_tvalid;
    logic [iat_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic                           accept;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [IW-1:0]                  pos_idx;
    logic                           pos_lt;
    logic                           pos_le;
    logic                           full;
    logic                           do_write;
    logic                           do_ins;
    logic                           do_rem;

    // Chain wiring
    iat_pkg::t_cell_ctl             ctl   [DEPTH];
    iat_pkg::t_cell_sts             sts   [DEPTH];
    logic [WIDTH-1:0]               words [DEPTH];
    logic [DEPTH-1:0]               first_vec;

    // Result fields
    iat_pkg::t_status               status;
    logic [KW-1:0]                  rd_wide;
    logic [iat_pkg::RDATA_W-1:0]    rdata;
    logic [iat_pkg::FOUND_W-1:0]    found;
    logic [iat_pkg::FOUND_W-1:0]    found_any;

    assign kind      = iat_pkg::t_kind'(i_s_tdata[iat_pkg::KIND_W-1:0]);
    assign position  = i_s_tdata[iat_pkg::KIND_W +: iat_pkg::POS_W];
    assign value     = i_s_tdata[iat_pkg::KIND_W + iat_pkg::POS_W +: iat_pkg::VALUE_W];
    assign value_ext = KW'(value);
    assign key       = value_ext[WIDTH-1:0];

    // Handshake: take an item unless a result is stuck in the output register
    assign o_s_tready = !r_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Position checks against the current fill
    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(r_count);
    assign pos_idx = pos_ext[IW-1:0];
    assign pos_lt  = pos_ext < cnt_ext;
    assign pos_le  = pos_ext <= cnt_ext;
    assign full    = r_count == CW'(DEPTH);

    assign do_write = accept && (kind == iat_pkg::KIND_WRITE) && pos_lt;
    assign do_ins   = accept && (kind == iat_pkg::KIND_INSERT) && pos_le && !full;
    assign do_rem   = accept && (kind == iat_pkg::KIND_REMOVE) && pos_lt;

    // Per-cell selection: load at an insert or write position, shift up above an insert, down from a remove
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ctl[i].live = PW'(i) < cnt_ext;
            ctl[i].sel  = iat_pkg::SEL_HOLD;
            if (do_ins) begin
                if (PW'(i) > pos_ext) begin
                    ctl[i].sel = iat_pkg::SEL_PREV;
                end else if (PW'(i) == pos_ext) begin
                    ctl[i].sel = iat_pkg::SEL_LOAD;
                end
            end else if (do_rem) begin
                if (PW'(i) >= pos_ext) begin
                    ctl[i].sel = iat_pkg::SEL_NEXT;
                end
            end else if (do_write && (PW'(i) == pos_ext)) begin
                ctl[i].sel = iat_pkg::SEL_LOAD;
            end
        end
    end

    // Row of cells, neighbours wired both ways, hit passed upwards
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] prev_w;
        logic [WIDTH-1:0] next_w;
        logic             hit_in;

        if (g == 0) begin : g_lo
            assign prev_w = '0;
            assign hit_in = 1'b0;
        end else begin : g_mid_lo
            assign prev_w = words[g-1];
            assign hit_in = sts[g-1].hit;
        end
        if (g == DEPTH - 1) begin : g_hi
            assign next_w = '0;
        end else begin : g_mid_hi
            assign next_w = words[g+1];
        end

        iat_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl[g]),
            .i_prev (prev_w),
            .i_next (next_w),
            .i_load (key),
            .i_key  (key),
            .i_hit  (hit_in),
            .o_word (words[g]),
            .o_sts  (sts[g])
        );

        assign first_vec[g] = sts[g].first;
    end

    // Encode the first matching cell
    always_comb begin
        found_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_vec[i]) begin
                found_any = found_any | iat_pkg::FOUND_W'(i);
            end
        end
    end

    // Status, read data, found index and new fill for this item
    always_comb begin
        status  = iat_pkg::ST_OK;
        rd_wide = '0;
        found   = '1;
        n_count = r_count;
        unique case (kind)
            iat_pkg::KIND_READ: begin
                if (pos_lt) begin
                    rd_wide = KW'(words[pos_idx]);
                end else begin
                    status = iat_pkg::ST_BADPOS;
                end
            end
            iat_pkg::KIND_WRITE: begin
                if (!pos_lt) begin
                    status = iat_pkg::ST_BADPOS;
                end
            end
            iat_pkg::KIND_INSERT: begin
                if (!pos_le) begin
                    status = iat_pkg::ST_BADPOS;
                end else if (full) begin
                    status = iat_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            iat_pkg::KIND_REMOVE: begin
                if (pos_lt) begin
                    n_count = r_count - CW'(1);
                end else begin
                    status = iat_pkg::ST_BADPOS;
                end
            end
            iat_pkg::KIND_SEARCH: begin
                if (|first_vec) begin
                    found = found_any;
                end
            end
            default: begin
                status = iat_pkg::ST_BADPOS;
            end
        endcase
    end

    assign rdata = rd_wide[iat_pkg::RDATA_W-1:0];

    // Hold fill count and output valid; load the result on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count    <= n_count;
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_tdata <= {{(iat_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                          iat_pkg::COUNT_W'(n_count), found, rdata, status};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // Fill never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above capacity");

    // At most one cell claims the first match
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("more than one first match");

    // A successful insert grows the fill by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow fill");

    // A successful remove shrinks the fill by one
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rem |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink fill");

endmodule

FILE: rtl/iat_cell.sv
// One storage cell of the indexed array table chain.
// Holds one word, shifts it to or takes it from its neighbours, and compares it
// with the search key. Depends on iat_pkg.
module iat_cell #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  iat_pkg::t_cell_ctl    i_ctl,
    input  logic [WIDTH-1:0]      i_prev,
    input  logic [WIDTH-1:0]      i_next,
    input  logic [WIDTH-1:0]      i_load,
    input  logic [WIDTH-1:0]      i_key,
    input  logic                  i_hit,
    output logic [WIDTH-1:0]      o_word,
    output iat_pkg::t_cell_sts    o_sts
);

    logic [WIDTH-1:0] r_word;
    logic [WIDTH-1:0] n_word;
    logic             match;

    // Pick the next word from hold, either neighbour or the load bus
    always_comb begin
        case (i_ctl.sel)
            iat_pkg::SEL_PREV: n_word = i_prev;
            iat_pkg::SEL_NEXT: n_word = i_next;
            iat_pkg::SEL_LOAD: n_word = i_load;
            default:           n_word = r_word;
        endcase
    end

    // Hold the word; payload needs no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Compare against the key and pass the hit along the chain
    assign match       = i_ctl.live && (r_word == i_key);
    assign o_sts.hit   = i_hit || match;
    assign o_sts.first = match && !i_hit;
    assign o_word      = r_word;

endmodule

FILE: test/tb.sv
// Self-checking testbench for indexed_array_table_unit: drives command items and checks results.
// Keeps its own shadow copy of the table to predict each result, with random gaps on both sides.
// Depends on iat_pkg and the indexed_array_table_unit RTL.
module tb;

    localparam int TABLE_DEPTH = 16;
    localparam int TABLE_WIDTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 10;

    // Kind codes that the block must reject
    localparam logic [iat_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [iat_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        iat_pkg::t_status                    status;
        logic [iat_pkg::RDATA_W-1:0]         read_data;
        logic [iat_pkg::FOUND_W-1:0]         found_index;
        logic [iat_pkg::COUNT_W-1:0]         count;
    } t_table_result;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic [iat_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                            i_m_tready = 1'b0;
    wire                             o_s_tready;
    wire                             o_m_tvalid;
    wire [iat_pkg::OUT_TDATA_W-1:0]  o_m_tdata;

    // Shadow table and the results still owed by the block
    logic [iat_pkg::VALUE_W-1:0]     shadow_words [TABLE_DEPTH];
    int                              shadow_fill = 0;
    t_table_result                   owed_results [$];
    logic [iat_pkg::VALUE_W-1:0]     value_pool [8];

    bit                     gaps_on = 1'b1;
    bit                     grow_phase = 1'b1;
    int                     cycle_count = 0;
    int                     mismatch_count = 0;
    int                     items_sent = 0;
    int                     results_seen = 0;
    int                     full_count = 0;
    int                     hit_count = 0;

    always #2 i_clk = ~i_clk;

    indexed_array_table_unit #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (TABLE_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Apply one accepted command to the shadow table and queue the result it owes
    task automatic predict_command(input logic [iat_pkg::KIND_W-1:0] kind,
                                   input logic [iat_pkg::POS_W-1:0] pos,
                                   input logic [iat_pkg::VALUE_W-1:0] value);
        t_table_result r;
        bit            hit;
        int            i;
        r.status      = iat_pkg::ST_OK;
        r.read_data   = '0;
        r.found_index = '1;
        hit           = 1'b0;
        case (kind)
            iat_pkg::KIND_READ: begin
                if (pos < shadow_fill) r.read_data = shadow_words[pos];
                else r.status = iat_pkg::ST_BADPOS;
            end
            iat_pkg::KIND_WRITE: begin
                if (pos < shadow_fill) shadow_words[pos] = value;
                else r.status = iat_pkg::ST_BADPOS;
            end
            iat_pkg::KIND_INSERT: begin
                if (pos > shadow_fill) begin
                    r.status = iat_pkg::ST_BADPOS;
                end else if (shadow_fill >= TABLE_DEPTH) begin
                    r.status = iat_pkg::ST_FULL;
                    full_count++;
                end else begin
                    for (i = shadow_fill; i > pos; i--) shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = value;
                    shadow_fill++;
                end
            end
            iat_pkg::KIND_REMOVE: begin
                if (pos < shadow_fill) begin
                    for (i = pos; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
                    shadow_fill--;
                end else begin
                    r.status = iat_pkg::ST_BADPOS;
                end
            end
            iat_pkg::KIND_SEARCH: begin
                for (i = 0; i < shadow_fill; i++) begin
                    if (!hit && shadow_words[i] == value) begin
                        r.found_index = 5'(i);
                        hit = 1'b1;
                    end
                end
                if (hit) hit_count++;
            end
            default: r.status = iat_pkg::ST_BADPOS;
        endcase
        r.count = 5'(shadow_fill);
        owed_results.push_back(r);
    endtask

    // Offer one item, with an occasional gap first, and hold it until accepted
    task automatic send_command(input logic [iat_pkg::KIND_W-1:0] kind,
                                input logic [iat_pkg::POS_W-1:0] pos,
                                input logic [iat_pkg::VALUE_W-1:0] value);
        if (gaps_on && $urandom_range(0, 99) < 16) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= iat_pkg::IN_TDATA_W'({$urandom(), $urandom()});
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {value, pos, kind};
        do @(posedge i_clk); while (!o_s_tready);
        predict_command(kind, pos, value);
        items_sent++;
    endtask

    task automatic note_mismatch(input string what, input logic [iat_pkg::VALUE_W-1:0] want,
                                 input logic [iat_pkg::VALUE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("MISMATCH at cycle %0d, result %0d, %s: expected %h, got %h",
                     cycle_count, results_seen, what, want, got);
    endtask

    // Stall the result side at random while gaps are on
    always @(posedge i_clk) begin
        i_m_tready <= gaps_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
    end

    // Compare each taken result with the oldest owed one
    always @(posedge i_clk) begin
        t_table_result got;
        t_table_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status      = iat_pkg::t_status'(o_m_tdata[1:0]);
            got.read_data   = o_m_tdata[33:2];
            got.found_index = o_m_tdata[38:34];
            got.count       = o_m_tdata[43:39];
            if (owed_results.size() == 0) begin
                note_mismatch("result with nothing owed", '0, o_m_tdata[31:0]);
            end else begin
                want = owed_results.pop_front();
                if (got.status != want.status)
                    note_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.read_data != want.read_data)
                    note_mismatch("read_data", want.read_data, got.read_data);
                if (got.found_index != want.found_index)
                    note_mismatch("found_index", 32'(want.found_index), 32'(got.found_index));
                if (got.count != want.count)
                    note_mismatch("count", 32'(want.count), 32'(got.count));
            end
            results_seen++;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results owed",
                     cycle_count, owed_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Commands on an empty table, including rejected kinds
    task automatic test_empty_table();
        send_command(iat_pkg::KIND_READ, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_WRITE, 5'd0, 32'hFFFF_FFFF);
        send_command(iat_pkg::KIND_REMOVE, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_SEARCH, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_INSERT, 5'd1, 32'h1234_5678);
        send_command(KIND_SPARE_HI, 5'd31, 32'hFFFF_FFFF);
        send_command(KIND_SPARE_LO, 5'd0, 32'h0);
    endtask

    // Fill to capacity at front, back and middle, then push past it
    task automatic test_fill_to_full();
        int i;
        send_command(iat_pkg::KIND_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_command(iat_pkg::KIND_INSERT, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_INSERT, 5'd2, 32'h8000_0000);
        for (i = 3; i < TABLE_DEPTH; i++)
            send_command(iat_pkg::KIND_INSERT, 5'($urandom_range(0, i)), $urandom());
        send_command(iat_pkg::KIND_INSERT, 5'd16, 32'hA5A5_5A5A);
        send_command(iat_pkg::KIND_INSERT, 5'd17, 32'h0);
        send_command(iat_pkg::KIND_INSERT, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Read, overwrite, search and remove at the ends of a full table
    task automatic test_edit_ends();
        send_command(iat_pkg::KIND_READ, 5'd15, 32'h0);
        send_command(iat_pkg::KIND_READ, 5'd16, 32'h0);
        send_command(iat_pkg::KIND_WRITE, 5'd15, 32'hFFFF_FFFF);
        send_command(iat_pkg::KIND_SEARCH, 5'd0, 32'hFFFF_FFFF);
        send_command(iat_pkg::KIND_SEARCH, 5'd0, 32'h0BAD_F00D);
        send_command(iat_pkg::KIND_REMOVE, 5'd15, 32'h0);
        send_command(iat_pkg::KIND_REMOVE, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_WRITE, 5'd0, 32'h5555_AAAA);
        send_command(iat_pkg::KIND_READ, 5'd0, 32'h0);
        send_command(iat_pkg::KIND_READ, 5'd31, 32'h0);
    endtask

    // Mostly valid commands that sweep the fill level up and down, with some noise
    task automatic random_commands(input int n);
        logic [iat_pkg::KIND_W-1:0]  kind;
        logic [iat_pkg::POS_W-1:0]   pos;
        logic [iat_pkg::VALUE_W-1:0] value;
        int                          pick;
        int                          grow_weight;
        repeat (n) begin
            if (shadow_fill == TABLE_DEPTH) grow_phase = 1'b0;
            else if (shadow_fill == 0) grow_phase = 1'b1;
            value = ($urandom_range(0, 1) != 0) ? value_pool[$urandom_range(0, 7)] : $urandom();
            if ($urandom_range(0, 99) < 8) begin
                kind  = iat_pkg::KIND_W'($urandom_range(0, 7));
                pos   = iat_pkg::POS_W'($urandom_range(0, 31));
                value = $urandom();
            end else begin
                grow_weight = grow_phase ? 35 : 12;
                pick = $urandom_range(0, 99);
                if (pick < grow_weight) kind = iat_pkg::KIND_INSERT;
                else if (pick < 47) kind = iat_pkg::KIND_REMOVE;
                else if (pick < 65) kind = iat_pkg::KIND_READ;
                else if (pick < 80) kind = iat_pkg::KIND_WRITE;
                else kind = iat_pkg::KIND_SEARCH;
                if (kind == iat_pkg::KIND_INSERT)
                    pos = iat_pkg::POS_W'($urandom_range(0, shadow_fill));
                else if (shadow_fill > 0)
                    pos = iat_pkg::POS_W'($urandom_range(0, shadow_fill - 1));
                else
                    pos = '0;
                if (kind == iat_pkg::KIND_SEARCH && shadow_fill > 0
                    && $urandom_range(0, 99) < 60)
                    value = shadow_words[$urandom_range(0, shadow_fill - 1)];
            end
            send_command(kind, pos, value);
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) shadow_words[i] = '0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (i = 4; i < 8; i++) value_pool[i] = $urandom();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_to_full();
        test_edit_ends();
        gaps_on = 1'b0;
        random_commands(400);
        gaps_on = 1'b1;
        random_commands(1200);
        i_s_tvalid <= 1'b0;

        // Drain the owed results, then allow for the output register
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results in %0d cycles",
                 items_sent, results_seen, cycle_count);
        $display("Full rejections: %0d, search hits: %0d, mismatches: %0d",
                 full_count, hit_count, mismatch_count);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
